FILE: src/pbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pbc_pkg;

   localparam int DEFAULT_COUNT_WIDTH = 16;
   localparam int DEFAULT_INDEL_WIDTH = 16;
   localparam int OUT_WIDTH           = 16;
   localparam int NUM_BASES           = 5;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_CARET = 8'h5E;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef enum logic [2:0] {
      BASE_A    = 3'd0,
      BASE_C    = 3'd1,
      BASE_G    = 3'd2,
      BASE_T    = 3'd3,
      BASE_N    = 3'd4,
      BASE_NONE = 3'd7
   } base_type;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_DIGITS = 2'd1,
      MODE_SKIP   = 2'd2,
      MODE_CARET  = 2'd3
   } mode_type;

   typedef struct packed {
      logic [7:0] ref_base;
      logic [7:0] symbol;
      logic       has_symbol;
      logic       last;
   } item_type;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] count_a;
      logic [OUT_WIDTH-1:0] count_c;
      logic [OUT_WIDTH-1:0] count_g;
      logic [OUT_WIDTH-1:0] count_t;
      logic [OUT_WIDTH-1:0] count_n;
      logic                 bad_line;
   } result_type;

   // case-insensitive nucleotide decode
   function automatic base_type base_decode(input logic [7:0] c);
      base_type b;
      case (c | 8'h20)
         8'h61:   b = BASE_A;
         8'h63:   b = BASE_C;
         8'h67:   b = BASE_G;
         8'h74:   b = BASE_T;
         8'h6E:   b = BASE_N;
         default: b = BASE_NONE;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

FILE: src/pileup_base_counter.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  ref_base, symbol, has_symbol, last
// rsp       out        rsp_valid/rsp_stall  count_a/c/g/t/n, bad_line
//
// One character per cycle unless a stalled result holds up a line end; a line's
// result is registered through the input register, then the result register.
// Synchronous active-high reset clears the parser and both valid flags.
// A stalled result only holds up a line-end transaction; others keep flowing.
`timescale 1ns / 1ps
`default_nettype none

module pileup_base_counter #(
   parameter int COUNT_WIDTH = pbc_pkg::DEFAULT_COUNT_WIDTH,
   parameter int INDEL_WIDTH = pbc_pkg::DEFAULT_INDEL_WIDTH
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  [7:0]                   req_ref_base,
   input  wire  [7:0]                   req_symbol,
   input  wire                          req_has_symbol,
   input  wire                          req_last,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [pbc_pkg::OUT_WIDTH-1:0] rsp_count_a,
   output logic [pbc_pkg::OUT_WIDTH-1:0] rsp_count_c,
   output logic [pbc_pkg::OUT_WIDTH-1:0] rsp_count_g,
   output logic [pbc_pkg::OUT_WIDTH-1:0] rsp_count_t,
   output logic [pbc_pkg::OUT_WIDTH-1:0] rsp_count_n,
   output logic                         rsp_bad_line
);
   import pbc_pkg::*;

   item_type   req_item, item;
   logic       item_valid, advance, load;
   result_type result, rsp_result;

   assign req_item.ref_base   = req_ref_base;
   assign req_item.symbol     = req_symbol;
   assign req_item.has_symbol = req_has_symbol;
   assign req_item.last       = req_last;

   assign advance = item_valid & (~item.last | ~rsp_valid | ~rsp_stall);
   assign load    = advance & item.last;

   pbc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   pbc_parser #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .INDEL_WIDTH (INDEL_WIDTH)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .result  (result)
   );

   pbc_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .result     (result),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   assign rsp_count_a  = rsp_result.count_a;
   assign rsp_count_c  = rsp_result.count_c;
   assign rsp_count_g  = rsp_result.count_g;
   assign rsp_count_t  = rsp_result.count_t;
   assign rsp_count_n  = rsp_result.count_n;
   assign rsp_bad_line = rsp_result.bad_line;

`ifndef NO_ASSERTIONS
   // never overwrite a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(load && rsp_valid && rsp_stall))
      else $error("result overwritten while stalled");

   // a held transaction stays in the input register
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      (item_valid && !advance) |=> item_valid)
      else $error("input transaction lost");

   // bad line reports zero counts
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_line) |-> (rsp_count_a == '0 && rsp_count_c == '0 &&
         rsp_count_g == '0 && rsp_count_t == '0 && rsp_count_n == '0))
      else $error("bad line with nonzero counts");

   // input stall only while a transaction is held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (item_valid && item.last && rsp_valid && rsp_stall))
      else $error("spurious input stall");
`endif

endmodule

`default_nettype wire

FILE: src/pbc_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module pbc_in_reg (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  pbc_pkg::item_type req_item,
   input  wire              advance,
   output logic             item_valid,
   output pbc_pkg::item_type item
);
   import pbc_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;

   assign req_stall = valid_ff & ~advance;

   always_comb begin
      valid_in = valid_ff;
      if (!req_stall) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

FILE: src/pbc_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module pbc_parser #(
   parameter int COUNT_WIDTH = pbc_pkg::DEFAULT_COUNT_WIDTH,
   parameter int INDEL_WIDTH = pbc_pkg::DEFAULT_INDEL_WIDTH
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 advance,
   input  pbc_pkg::item_type   item,
   output pbc_pkg::result_type result
);
   import pbc_pkg::*;

   localparam int PROD_WIDTH = INDEL_WIDTH + 4;

   mode_type               mode_ff, mode_in;
   logic [INDEL_WIDTH-1:0] skip_ff, skip_in;
   logic [COUNT_WIDTH-1:0] cnt_ff [NUM_BASES];
   logic [COUNT_WIDTH-1:0] cnt_in [NUM_BASES];
   logic [OUT_WIDTH-1:0]   cnt_out [NUM_BASES];
   logic                   error_ff, error_in;

   base_type ref_sel, sym_sel, bump_sel;
   logic     ref_ok, err_now, active, normal_act, bad_char;
   logic     is_digit, is_pm, is_dc, is_caret, is_ign, sym_ok, skip_zero;
   mode_type normal_next;
   logic [PROD_WIDTH-1:0] prod;
   logic [INDEL_WIDTH-1:0] digit_acc;
   logic     clear;

   assign ref_sel  = base_decode(item.ref_base);
   assign sym_sel  = base_decode(item.symbol);
   assign ref_ok   = (ref_sel != BASE_NONE);
   assign sym_ok   = (sym_sel != BASE_NONE);
   assign is_digit = (item.symbol >= CHAR_ZERO) && (item.symbol <= CHAR_NINE);
   assign is_pm    = (item.symbol == CHAR_PLUS) || (item.symbol == CHAR_MINUS);
   assign is_dc    = (item.symbol == CHAR_DOT) || (item.symbol == CHAR_COMMA);
   assign is_caret = (item.symbol == CHAR_CARET);
   assign is_ign   = (item.symbol == CHAR_DOLLAR) || (item.symbol == CHAR_STAR);
   assign skip_zero = (skip_ff == '0);

   assign err_now    = error_ff | ~ref_ok;
   assign active     = ~err_now & item.has_symbol;
   assign normal_act = active & ((mode_ff == MODE_NORMAL) ||
                                 ((mode_ff == MODE_DIGITS) && !is_digit && skip_zero));
   assign bad_char   = normal_act & ~is_pm & ~is_dc & ~is_caret & ~is_ign & ~sym_ok;
   assign error_in   = err_now | bad_char;
   assign clear      = advance & item.last;

   assign normal_next = is_pm ? MODE_DIGITS : (is_caret ? MODE_CARET : MODE_NORMAL);

   // indel length: skip * 10 + digit, saturating
   assign prod = ({4'b0, skip_ff} << 3) + ({4'b0, skip_ff} << 1)
               + {{(PROD_WIDTH-4){1'b0}}, item.symbol[3:0]};
   assign digit_acc = (|prod[PROD_WIDTH-1:INDEL_WIDTH]) ? '1 : prod[INDEL_WIDTH-1:0];

   // next mode
   always_comb begin
      mode_in = mode_ff;
      if (active) begin
         case (mode_ff)
            MODE_NORMAL: mode_in = normal_next;
            MODE_DIGITS: begin
               if (is_digit) begin
                  mode_in = MODE_DIGITS;
               end else if (!skip_zero) begin
                  mode_in = (skip_ff != INDEL_WIDTH'(1)) ? MODE_SKIP : MODE_NORMAL;
               end else begin
                  mode_in = normal_next;
               end
            end
            MODE_SKIP: begin
               if (skip_ff <= INDEL_WIDTH'(1)) begin
                  mode_in = MODE_NORMAL;
               end
            end
            MODE_CARET: mode_in = MODE_NORMAL;
            default:    mode_in = MODE_NORMAL;
         endcase
      end
   end

   // skip length and counters
   always_comb begin
      skip_in  = skip_ff;
      bump_sel = BASE_NONE;
      if (active && (mode_ff == MODE_DIGITS) && is_digit) begin
         skip_in = digit_acc;
      end else if (active && !skip_zero &&
                   ((mode_ff == MODE_DIGITS) || (mode_ff == MODE_SKIP))) begin
         skip_in = skip_ff - INDEL_WIDTH'(1);
      end else if (normal_act && is_pm) begin
         skip_in = '0;
      end
      if (normal_act && is_dc) begin
         bump_sel = ref_sel;
      end else if (normal_act && sym_ok && !is_pm && !is_caret) begin
         bump_sel = sym_sel;
      end
   end

   for (genvar k = 0; k < NUM_BASES; k++) begin : g_cnt
      always_comb begin
         cnt_in[k] = cnt_ff[k];
         if ((bump_sel == base_type'(k)) && (cnt_ff[k] != '1)) begin
            cnt_in[k] = cnt_ff[k] + COUNT_WIDTH'(1);
         end
      end
      if (COUNT_WIDTH > OUT_WIDTH) begin : g_clip
         assign cnt_out[k] = (|cnt_in[k][COUNT_WIDTH-1:OUT_WIDTH]) ? '1 :
                             cnt_in[k][OUT_WIDTH-1:0];
      end else begin : g_ext
         assign cnt_out[k] = OUT_WIDTH'(cnt_in[k]);
      end
      always_ff @(posedge clock) begin
         if (reset || clear) begin
            cnt_ff[k] <= '0;
         end else if (advance) begin
            cnt_ff[k] <= cnt_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         mode_ff  <= MODE_NORMAL;
         skip_ff  <= '0;
         error_ff <= 1'b0;
      end else if (advance) begin
         mode_ff  <= mode_in;
         skip_ff  <= skip_in;
         error_ff <= error_in;
      end
   end

   always_comb begin
      result.bad_line = error_in;
      result.count_a  = error_in ? '0 : cnt_out[BASE_A];
      result.count_c  = error_in ? '0 : cnt_out[BASE_C];
      result.count_g  = error_in ? '0 : cnt_out[BASE_G];
      result.count_t  = error_in ? '0 : cnt_out[BASE_T];
      result.count_n  = error_in ? '0 : cnt_out[BASE_N];
   end

endmodule

`default_nettype wire

FILE: src/pbc_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module pbc_out_reg (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 load,
   input  pbc_pkg::result_type result,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output pbc_pkg::result_type rsp_result
);
   import pbc_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff;

   always_comb begin
      valid_in = valid_ff & rsp_stall;
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

`default_nettype wire

FILE: tb/pileup_base_counter_checker.sv
`timescale 1ns / 1ps

module pileup_base_counter_checker
   import pbc_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   input  wire                 req_stall,
   input  wire [7:0]           req_ref_base,
   input  wire [7:0]           req_symbol,
   input  wire                 req_has_symbol,
   input  wire                 req_last,
   input  wire                 rsp_valid,
   input  wire                 rsp_stall,
   input  wire [OUT_WIDTH-1:0] rsp_count_a,
   input  wire [OUT_WIDTH-1:0] rsp_count_c,
   input  wire [OUT_WIDTH-1:0] rsp_count_g,
   input  wire [OUT_WIDTH-1:0] rsp_count_t,
   input  wire [OUT_WIDTH-1:0] rsp_count_n,
   input  wire                 rsp_bad_line,
   output int                  fail_count,
   output int                  pending
);

   localparam int unsigned COUNT_MAX = (64'd1 << DEFAULT_COUNT_WIDTH) - 1;
   localparam int unsigned INDEL_MAX = (64'd1 << DEFAULT_INDEL_WIDTH) - 1;

   mode_type    parse_mode;
   int unsigned skip_left;
   int unsigned tally [NUM_BASES];
   bit          line_bad;
   result_type  line_counts_q [$];
   int          mismatches = 0;

   initial begin
      fail_count = 0;
      pending = 0;
   end

   function automatic base_type to_base(input logic [7:0] c);
      case (c)
         "a", "A": return BASE_A;
         "c", "C": return BASE_C;
         "g", "G": return BASE_G;
         "t", "T": return BASE_T;
         "n", "N": return BASE_N;
         default:  return BASE_NONE;
      endcase
   endfunction

   task automatic restart_line();
      parse_mode = MODE_NORMAL;
      skip_left = 0;
      foreach (tally[k]) tally[k] = 0;
      line_bad = 1'b0;
   endtask

   task automatic count_base(input base_type b);
      if (b != BASE_NONE && tally[b] < COUNT_MAX) tally[b]++;
   endtask

   task automatic plain_char(input logic [7:0] c, input base_type ref_b);
      if (c == CHAR_PLUS || c == CHAR_MINUS) begin
         parse_mode = MODE_DIGITS;
         skip_left = 0;
      end else if (c == CHAR_DOT || c == CHAR_COMMA) begin
         count_base(ref_b);
      end else if (c == CHAR_CARET) begin
         parse_mode = MODE_CARET;
      end else if (c != CHAR_DOLLAR && c != CHAR_STAR) begin
         if (to_base(c) == BASE_NONE) line_bad = 1'b1;
         else count_base(to_base(c));
      end
   endtask

   task automatic take_char(input logic [7:0] c, input base_type ref_b);
      int unsigned v;
      case (parse_mode)
         MODE_DIGITS: begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
               v = skip_left * 10 + 32'(c - CHAR_ZERO);
               skip_left = (v > INDEL_MAX) ? INDEL_MAX : v;
            end else if (skip_left > 0) begin
               skip_left--;
               parse_mode = (skip_left > 0) ? MODE_SKIP : MODE_NORMAL;
            end else begin
               parse_mode = MODE_NORMAL;
               plain_char(c, ref_b);
            end
         end
         MODE_SKIP: begin
            if (skip_left > 0) skip_left--;
            if (skip_left == 0) parse_mode = MODE_NORMAL;
         end
         MODE_CARET: parse_mode = MODE_NORMAL;
         default:    plain_char(c, ref_b);
      endcase
   endtask

   task automatic absorb(input item_type it);
      base_type   ref_b;
      result_type want;
      ref_b = to_base(it.ref_base);
      if (!line_bad && ref_b == BASE_NONE) line_bad = 1'b1;
      if (!line_bad && it.has_symbol) take_char(it.symbol, ref_b);
      if (it.last) begin
         want.count_a  = line_bad ? '0 : OUT_WIDTH'(tally[BASE_A]);
         want.count_c  = line_bad ? '0 : OUT_WIDTH'(tally[BASE_C]);
         want.count_g  = line_bad ? '0 : OUT_WIDTH'(tally[BASE_G]);
         want.count_t  = line_bad ? '0 : OUT_WIDTH'(tally[BASE_T]);
         want.count_n  = line_bad ? '0 : OUT_WIDTH'(tally[BASE_N]);
         want.bad_line = line_bad;
         line_counts_q.push_back(want);
         restart_line();
      end
   endtask

   task automatic check_counts(input result_type got);
      result_type want;
      if (line_counts_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected rsp transaction: a=%0d c=%0d g=%0d t=%0d n=%0d bad=%0b",
                     got.count_a, got.count_c, got.count_g, got.count_t, got.count_n,
                     got.bad_line);
         return;
      end
      want = line_counts_q.pop_front();
      if (got.count_a !== want.count_a || got.count_c !== want.count_c ||
          got.count_g !== want.count_g || got.count_t !== want.count_t ||
          got.count_n !== want.count_n || got.bad_line !== want.bad_line) begin
         mismatches++;
         if (mismatches <= 10)
            $display("rsp mismatch: expected a=%0d c=%0d g=%0d t=%0d n=%0d bad=%0b, %s",
                     want.count_a, want.count_c, want.count_g, want.count_t,
                     want.count_n, want.bad_line,
                     $sformatf("got a=%0d c=%0d g=%0d t=%0d n=%0d bad=%0b",
                               got.count_a, got.count_c, got.count_g, got.count_t,
                               got.count_n, got.bad_line));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restart_line();
         line_counts_q.delete();
      end else begin
         if (req_valid && !req_stall)
            absorb('{req_ref_base, req_symbol, req_has_symbol, req_last});
         if (rsp_valid && !rsp_stall)
            check_counts('{rsp_count_a, rsp_count_c, rsp_count_g, rsp_count_t,
                           rsp_count_n, rsp_bad_line});
      end
      fail_count <= mismatches;
      pending <= line_counts_q.size();
   end

endmodule

FILE: tb/pileup_base_counter_test.sv
`timescale 1ns / 1ps

module pileup_base_counter_test;
   import pbc_pkg::*;

   localparam int CYCLE_LIMIT  = 50000;
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASE_ITEMS  = 300;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [7:0]           req_ref_base = '0;
   logic [7:0]           req_symbol = '0;
   logic                 req_has_symbol = 1'b0;
   logic                 req_last = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [OUT_WIDTH-1:0] rsp_count_a, rsp_count_c, rsp_count_g, rsp_count_t, rsp_count_n;
   logic                 rsp_bad_line;

   int fail_count;
   int pending;
   int tx_idle = 10;
   int rx_idle = 58;
   bit hold_req = 1'b0;
   int held = 0;
   int cycles = 0;
   int items_sent = 0;

   pileup_base_counter dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_ref_base, .req_symbol, .req_has_symbol, .req_last,
      .rsp_valid, .rsp_stall, .rsp_count_a, .rsp_count_c, .rsp_count_g, .rsp_count_t,
      .rsp_count_n, .rsp_bad_line
   );

   pileup_base_counter_checker watcher (
      .clock, .reset,
      .req_valid, .req_stall, .req_ref_base, .req_symbol, .req_has_symbol, .req_last,
      .rsp_valid, .rsp_stall, .rsp_count_a, .rsp_count_c, .rsp_count_g, .rsp_count_t,
      .rsp_count_n, .rsp_bad_line, .fail_count, .pending
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: one long hold-off on request, otherwise random stalls
   always @(posedge clock) begin
      if (hold_req && held < HOLD_CYCLES) begin
         rsp_stall <= 1'b1;
         held <= held + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("pileup_base_counter test failed");
         $finish;
      end
   end

   task automatic send_item(input logic [7:0] ref_ch, input logic [7:0] sym,
                            input logic has, input logic fin);
      while ($urandom_range(99) < tx_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_ref_base   <= ref_ch;
      req_symbol     <= sym;
      req_has_symbol <= has;
      req_last       <= fin;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_line(input logic [7:0] ref_ch, input string s);
      if (s.len() == 0) send_item(ref_ch, 8'($urandom_range(255)), 1'b0, 1'b1);
      for (int k = 0; k < s.len(); k++) send_item(ref_ch, s[k], 1'b1, k == s.len() - 1);
   endtask

   function automatic logic [7:0] rand_base();
      string      letters;
      logic [7:0] c;
      letters = "ACGTN";
      c = letters[$urandom_range(4)];
      if ($urandom_range(1)) c = c | 8'h20;
      return c;
   endfunction

   task automatic send_random_line();
      logic [7:0] ref_ch;
      logic [7:0] chars [$];
      string      digits;
      int         len, r, n;
      ref_ch = ($urandom_range(99) < 4) ? 8'($urandom_range(255)) : rand_base();
      len = $urandom_range(12);
      while (chars.size() < len) begin
         r = $urandom_range(99);
         if (r < 45) begin
            chars.push_back(rand_base());
         end else if (r < 62) begin
            chars.push_back(r[0] ? CHAR_DOT : CHAR_COMMA);
         end else if (r < 72) begin
            chars.push_back(r[0] ? CHAR_PLUS : CHAR_MINUS);
            n = $urandom_range(12);
            if ($urandom_range(7) != 0) begin
               digits = $sformatf("%0d", n);
               for (int k = 0; k < digits.len(); k++) chars.push_back(digits[k]);
            end
            n = n + $urandom_range(2) - 1;
            for (int k = 0; k < n; k++) chars.push_back(rand_base());
         end else if (r < 78) begin
            chars.push_back(CHAR_CARET);
            chars.push_back(8'($urandom_range(33, 126)));
         end else if (r < 84) begin
            chars.push_back(r[0] ? CHAR_DOLLAR : CHAR_STAR);
         end else if (r < 88) begin
            chars.push_back(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
         end else if (r < 97) begin
            chars.push_back(rand_base());
         end else begin
            chars.push_back(8'($urandom_range(255)));
         end
      end
      if (chars.size() == 0) send_item(ref_ch, 8'($urandom_range(255)), 1'b0, 1'b1);
      foreach (chars[k])
         send_item(ref_ch, chars[k], ($urandom_range(99) >= 3), k == chars.size() - 1);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed lines
      send_line("A", ".aCgTn$*,");
      send_line("g", "+2ACT");
      send_line("C", "^X,");
      send_line("t", "-a");
      send_line("X", "");
      send_line("N", "");
      send_line("A", "QA");
      send_line("a", "+99999G");
      send_line("c", "^");
      wait_drain();

      for (int phase = 0; phase < 3; phase++) begin
         tx_idle = (phase == 0) ? 10 : (phase == 1) ? 58 : 0;
         rx_idle <= (phase == 0) ? 58 : (phase == 1) ? 10 : 0;
         if (phase == 2) hold_req <= 1'b1;
         while (items_sent < PHASE_ITEMS * (phase + 1) + 30) send_random_line();
         wait_drain();
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("pileup_base_counter test passed");
      end else begin
         $display("pileup_base_counter test failed");
      end
      $finish;
   end

endmodule
